/* design/ftf_pkg.sv */
// Shared constants, types and decode function of the force/torque frame filter.
package ftf_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int CHANNELS      = 6;
    localparam int RAW_W         = 16;
    localparam int ID_W          = 11;
    localparam int VAL_W         = 26;
    localparam int OUT_W         = 25;
    localparam int WEIGHT_W      = 16;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int DIFF_W        = VAL_W + 1;
    localparam int PROD_W        = DIFF_W + WEIGHT_W + 1;

    localparam int IN_DATA_W     = 48;
    localparam int IN_USER_W     = 12;
    localparam int OUT_DATA_W    = 152;
    localparam int OUT_USER_W    = 1;

    localparam logic [ID_W-1:0]       FORCE_FRAME_ID  = 11'd1;
    localparam logic [RAW_W-1:0]      FORCE_OFFSET    = 16'd30000;
    localparam logic [RAW_W-1:0]      TORQUE_OFFSET   = 16'd25000;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET    = 16'd33567;
    localparam logic [CNT_W-1:0]      CAL_LEN_RESET   = 8'd100;
    localparam logic [CNT_W-1:0]      CNT_MAX         = 8'd255;

    localparam logic [CFG_IDX_W-1:0]  CFG_WEIGHT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_CAL_LENGTH  = 1'd1;

    typedef logic signed [VAL_W-1:0] t_val;

    // raw - offset (or offset - raw), scaled up by the fraction bits
    function automatic t_val decode(input logic [RAW_W-1:0] raw,
                                    input logic [RAW_W-1:0] offset,
                                    input logic neg);
        logic signed [RAW_W+1:0] d;
        t_val                    d_ext;
        if (neg) begin
            d = $signed({2'b00, offset}) - $signed({2'b00, raw});
        end else begin
            d = $signed({2'b00, raw}) - $signed({2'b00, offset});
        end
        d_ext = t_val'(d);
        return d_ext <<< FRACTION_BITS;
    endfunction

endpackage

/* design/ftf_chan.sv */
// One channel's low-pass step: filt + floor(weight * (last - filt) / 2^16).
module ftf_chan (
    input  ftf_pkg::t_val                        i_last,
    input  ftf_pkg::t_val                        i_filt,
    input  logic [ftf_pkg::WEIGHT_W-1:0]         i_weight,
    output ftf_pkg::t_val                        o_filt
);
    import ftf_pkg::*;

    logic signed [DIFF_W-1:0]     diff;
    logic signed [PROD_W-1:0]     prod;
    logic signed [WEIGHT_W:0]     weight_s;

    assign weight_s = $signed({1'b0, i_weight});
    assign diff     = DIFF_W'(i_last) - DIFF_W'(i_filt);
    assign prod     = PROD_W'(diff) * PROD_W'(weight_s);

    // arithmetic shift gives the floor; the step always fits the state width
    assign o_filt   = i_filt + t_val'(prod >>> WEIGHT_W);

endmodule

/* design/force_torque_frame_filter.sv */
// Six-axis force/torque frame filter with bias capture, top level.
//
// Input stream: one beat per sensor frame. tdata carries word_a, word_b and
// word_c; tuser carries frame_id and error_frame. Frame id 1 updates the
// three forces, any other id the three torques; an error frame updates none.
// Output stream: one beat per frame with the six filtered channels and the
// calibration-done flag. Configuration writes (weight, calibration length)
// are taken on any cycle with the write enable high; the user must write them
// only while the block is idle, which the block does not enforce. The path has
// one input register, then the decode, six parallel 27x17 multiplies and adds
// feed the channel state and the output register in the same cycle. One frame
// per cycle is sustained while the receiver is ready; the state recurrence
// closes in its own register. When the receiver stalls, the output register
// holds its beat and the input register holds one more before s_axis_tready drops.
// Reset clears the channel state, the bias, the frame count and the flag,
// and loads the weight and calibration length with their default values.
module force_torque_frame_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // word_a [15:0], word_b [31:16], word_c [47:32]
    input  logic [ftf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // frame_id [10:0], error_frame [11]
    input  logic [ftf_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z (25 bits each), 2 pad
    output logic [ftf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // ready_res [0]
    output logic [ftf_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [ftf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ftf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import ftf_pkg::*;

    logic                   r_in_valid;
    logic [IN_DATA_W-1:0]   r_in_data;
    logic [IN_USER_W-1:0]   r_in_user;

    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_val [CHANNELS];
    logic                   r_out_ready_res;

    logic [WEIGHT_W-1:0]    r_weight;
    logic [CNT_W-1:0]       r_cal_len;

    t_val                   r_last [CHANNELS];
    t_val                   r_filt [CHANNELS];
    t_val                   r_bias [CHANNELS];
    logic [CNT_W-1:0]       r_frames;
    logic                   r_calibrated;

    t_val                   n_last [CHANNELS];
    t_val                   n_filt [CHANNELS];
    t_val                   dec    [CHANNELS];
    logic [CNT_W-1:0]       n_frames;
    logic                   capture;
    logic                   advance;
    logic                   is_force;
    logic                   is_err;
    logic [RAW_W-1:0]       word_a;
    logic [RAW_W-1:0]       word_b;
    logic [RAW_W-1:0]       word_c;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign word_a   = r_in_data[RAW_W-1:0];
    assign word_b   = r_in_data[2*RAW_W-1:RAW_W];
    assign word_c   = r_in_data[3*RAW_W-1:2*RAW_W];
    assign is_force = (r_in_user[ID_W-1:0] == FORCE_FRAME_ID);
    assign is_err   = r_in_user[ID_W];

    always_comb begin
        dec[0] = decode(word_a, FORCE_OFFSET, 1'b0);
        dec[1] = decode(word_b, FORCE_OFFSET, 1'b0);
        dec[2] = decode(word_c, FORCE_OFFSET, 1'b0);
        dec[3] = decode(word_a, TORQUE_OFFSET, 1'b0);
        dec[4] = decode(word_b, TORQUE_OFFSET, 1'b0);
        dec[5] = decode(word_c, TORQUE_OFFSET, 1'b1);
        for (int i = 0; i < CHANNELS; i++) begin
            n_last[i] = r_last[i];
            if (!is_err && (is_force == (i < 3))) begin
                n_last[i] = dec[i] - r_bias[i];
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        ftf_chan u_chan (
            .i_last   (n_last[g]),
            .i_filt   (r_filt[g]),
            .i_weight (r_weight),
            .o_filt   (n_filt[g])
        );
    end

    // saturating frame count; capture once the count reaches the length
    assign n_frames = (r_frames == CNT_MAX) ? r_frames : r_frames + 1'b1;
    assign capture  = !r_calibrated && (n_frames >= r_cal_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= WEIGHT_RESET;
            r_cal_len <= CAL_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WEIGHT:     r_weight  <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_CAL_LENGTH: r_cal_len <= i_cfg_wdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
                r_filt[i] <= '0;
                r_bias[i] <= '0;
            end
            r_frames     <= '0;
            r_calibrated <= 1'b0;
        end else if (advance) begin
            if (!r_calibrated) begin
                r_frames <= n_frames;
            end
            if (capture) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_bias[i] <= n_filt[i];
                    r_filt[i] <= '0;
                    r_last[i] <= '0;
                end
                r_calibrated <= 1'b1;
            end else begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_filt[i] <= n_filt[i];
                    r_last[i] <= n_last[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_out_val[i] <= capture ? '0 : n_filt[i][OUT_W-1:0];
            end
            r_out_ready_res <= r_calibrated || capture;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_val[5], r_out_val[4], r_out_val[3],
                            r_out_val[2], r_out_val[1], r_out_val[0]};
    assign m_axis_tuser  = r_out_ready_res;

endmodule
